/* rtl/core/bpwc_pkg.sv */
// Shared types, widths and constants of the balance PID wheel command block.
package bpwc_pkg;

   localparam int ERR_W       = 16;   // Q4.12 error and angles
   localparam int POS_W       = 32;   // Q16.16 positions and commands
   localparam int GAIN_W      = 16;   // unsigned Q8.8 gains
   localparam int SUM_W       = 32;   // error integral
   localparam int DIFF_W      = ERR_W + 1;
   localparam int MUL_A_W     = SUM_W + 1;
   localparam int MUL_B_W     = GAIN_W + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_W       = PROD_W;
   localparam int FRAC_DROP   = 4;    // Q12.20 to Q16.16
   localparam int FB_W        = ACC_W - FRAC_DROP;
   localparam int CMD_SUM_W   = FB_W + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [MUL_B_W-1:0] DERIV_RATE = 17'd200;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = 50'sd8;

   localparam logic [GAIN_W-1:0]       GAIN_P_RESET   = 16'd19200;
   localparam logic [GAIN_W-1:0]       GAIN_I_RESET   = 16'd2560;
   localparam logic [GAIN_W-1:0]       GAIN_D_RESET   = 16'd25600;
   localparam logic signed [ERR_W-1:0] TARGET_RESET   = 16'sd0;
   localparam logic signed [ERR_W-1:0] LEVEL_RESET    = 16'sd205;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GAIN_P = 3'd0,
      REG_GAIN_I = 3'd1,
      REG_GAIN_D = 3'd2,
      REG_TARGET = 3'd3,
      REG_LEVEL  = 3'd4
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MP,
      ST_MI,
      ST_MD1,
      ST_MD2,
      ST_ACC,
      ST_FB,
      ST_CMD
   } state_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] pitch_angle;
      logic signed [POS_W-1:0] left_wheel_pos;
      logic signed [POS_W-1:0] right_wheel_pos;
   } req_payload_type;

   typedef struct packed {
      logic signed [POS_W-1:0] left_wheel_cmd;
      logic signed [POS_W-1:0] right_wheel_cmd;
   } rsp_payload_type;

endpackage

/* rtl/core/balance_pid_wheel_command.sv */
// Balancing PID controller that turns a pitch sample into two wheel position commands.
//
// Usage:
//  - Request channel (req_valid/req_ready/req_payload): one control tick, carrying the
//    measured pitch (Q4.12) and both wheel positions (Q16.16).
//  - Response channel (rsp_valid/rsp_ready/rsp_payload): one pair of saturated wheel
//    commands per request, in request order.
//  - CSR port (csr_wr_en/csr_index/csr_wdata): gains, pitch target and integral reset
//    level; write only while no request is in flight. Unknown indexes are dropped.
// Sequencing:
//  - A request steps through ERR, MP, MI, MD1, MD2, ACC, FB and CMD in order; its
//    response is registered when CMD is left. One 33x17 signed multiplier is shared
//    by the three PID terms and the derivative rate scaling, so the next request is
//    taken only after the sequencer is back in idle, where req_ready is high.
// Reset:
//  - Synchronous, active high. Clears the integral and the previous error, loads
//    the default gains (75.0, 10.0, 100.0), target 0 and reset level 205.
// Stall:
//  - The response sits in an output register. The next request is taken while it
//    waits; that request's result holds in the last step until the register frees.
module balance_pid_wheel_command (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bpwc_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bpwc_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_wr_en,
   input  logic [bpwc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bpwc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // configuration registers
   logic [bpwc_pkg::GAIN_W-1:0]        gain_p_ff;
   logic [bpwc_pkg::GAIN_W-1:0]        gain_i_ff;
   logic [bpwc_pkg::GAIN_W-1:0]        gain_d_ff;
   logic signed [bpwc_pkg::ERR_W-1:0]  target_ff;
   logic signed [bpwc_pkg::ERR_W-1:0]  level_ff;

   // sequencer and controller state
   bpwc_pkg::state_type                state_ff, state_in;
   logic signed [bpwc_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic signed [bpwc_pkg::ERR_W-1:0]  prev_ff, prev_in;

   // working registers of one request
   bpwc_pkg::req_payload_type          req_ff, req_in;
   logic signed [bpwc_pkg::ERR_W-1:0]  err_ff, err_in;
   logic signed [bpwc_pkg::DIFF_W-1:0] diff_ff, diff_in;
   logic signed [bpwc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [bpwc_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [bpwc_pkg::FB_W-1:0]   fb_ff, fb_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   bpwc_pkg::rsp_payload_type          rsp_ff, rsp_in;

   // shared multiplier operands
   logic signed [bpwc_pkg::MUL_A_W-1:0] mul_a;
   logic signed [bpwc_pkg::MUL_B_W-1:0] mul_b;

   // error step helpers
   logic signed [bpwc_pkg::DIFF_W-1:0]  raw_err;
   logic signed [bpwc_pkg::ERR_W-1:0]   err_sat;
   logic signed [bpwc_pkg::SUM_W:0]     sum_wide;
   logic signed [bpwc_pkg::SUM_W-1:0]   sum_sat;
   logic signed [bpwc_pkg::ACC_W-1:0]   acc_round;
   logic                                load_rsp;

   // Clamp a widened command sum to signed 32 bits.
   function automatic logic signed [bpwc_pkg::POS_W-1:0] sat_cmd(
      input logic signed [bpwc_pkg::CMD_SUM_W-1:0] v
   );
      logic top_same;
      top_same = (&v[bpwc_pkg::CMD_SUM_W-1:bpwc_pkg::POS_W-1]) ||
                 !(|v[bpwc_pkg::CMD_SUM_W-1:bpwc_pkg::POS_W-1]);
      if (top_same) begin
         sat_cmd = v[bpwc_pkg::POS_W-1:0];
      end else if (v[bpwc_pkg::CMD_SUM_W-1]) begin
         sat_cmd = {1'b1, {(bpwc_pkg::POS_W-1){1'b0}}};
      end else begin
         sat_cmd = {1'b0, {(bpwc_pkg::POS_W-1){1'b1}}};
      end
   endfunction

   assign req_ready   = (state_ff == bpwc_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Configuration writes; unknown indexes drop.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= bpwc_pkg::GAIN_P_RESET;
         gain_i_ff <= bpwc_pkg::GAIN_I_RESET;
         gain_d_ff <= bpwc_pkg::GAIN_D_RESET;
         target_ff <= bpwc_pkg::TARGET_RESET;
         level_ff  <= bpwc_pkg::LEVEL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bpwc_pkg::REG_GAIN_P: gain_p_ff <= csr_wdata;
            bpwc_pkg::REG_GAIN_I: gain_i_ff <= csr_wdata;
            bpwc_pkg::REG_GAIN_D: gain_d_ff <= csr_wdata;
            bpwc_pkg::REG_TARGET: target_ff <= csr_wdata;
            bpwc_pkg::REG_LEVEL:  level_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Error, saturated to 16 bits, the saturating integral update and the rounding bias.
   always_comb begin
      raw_err = {req_ff.pitch_angle[bpwc_pkg::ERR_W-1], req_ff.pitch_angle} -
                {target_ff[bpwc_pkg::ERR_W-1], target_ff};
      if (raw_err[bpwc_pkg::DIFF_W-1] == raw_err[bpwc_pkg::ERR_W-1]) begin
         err_sat = raw_err[bpwc_pkg::ERR_W-1:0];
      end else if (raw_err[bpwc_pkg::DIFF_W-1]) begin
         err_sat = {1'b1, {(bpwc_pkg::ERR_W-1){1'b0}}};
      end else begin
         err_sat = {1'b0, {(bpwc_pkg::ERR_W-1){1'b1}}};
      end
      sum_wide = {sum_ff[bpwc_pkg::SUM_W-1], sum_ff} +
                 (bpwc_pkg::SUM_W+1)'(err_sat);
      if (sum_wide[bpwc_pkg::SUM_W] == sum_wide[bpwc_pkg::SUM_W-1]) begin
         sum_sat = sum_wide[bpwc_pkg::SUM_W-1:0];
      end else if (sum_wide[bpwc_pkg::SUM_W]) begin
         sum_sat = {1'b1, {(bpwc_pkg::SUM_W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(bpwc_pkg::SUM_W-1){1'b1}}};
      end
      acc_round = acc_ff + bpwc_pkg::ROUND_BIAS;
   end

   // Sequencer: next state, multiplier operand select and register updates.
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      prev_in      = prev_ff;
      req_in       = req_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      fb_in        = fb_ff;
      rsp_in       = rsp_ff;
      mul_a        = bpwc_pkg::MUL_A_W'(err_ff);
      mul_b        = {1'b0, gain_p_ff};
      load_rsp     = 1'b0;

      unique case (state_ff)
         bpwc_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = bpwc_pkg::ST_ERR;
            end
         end
         bpwc_pkg::ST_ERR: begin
            err_in  = err_sat;
            diff_in = bpwc_pkg::DIFF_W'(err_sat) - bpwc_pkg::DIFF_W'(prev_ff);
            prev_in = err_sat;
            // clear the integral once the error reaches the reset level
            sum_in  = (err_sat >= level_ff) ? '0 : sum_sat;
            state_in = bpwc_pkg::ST_MP;
         end
         bpwc_pkg::ST_MP: begin
            // proportional product: kp * err
            state_in = bpwc_pkg::ST_MI;
         end
         bpwc_pkg::ST_MI: begin
            acc_in   = prod_ff;
            mul_a    = bpwc_pkg::MUL_A_W'(sum_ff);
            mul_b    = {1'b0, gain_i_ff};
            state_in = bpwc_pkg::ST_MD1;
         end
         bpwc_pkg::ST_MD1: begin
            acc_in   = acc_ff + prod_ff;
            mul_a    = bpwc_pkg::MUL_A_W'(diff_ff);
            mul_b    = bpwc_pkg::DERIV_RATE;
            state_in = bpwc_pkg::ST_MD2;
         end
         bpwc_pkg::ST_MD2: begin
            // 200 * diff fits well inside the 33-bit operand
            mul_a    = prod_ff[bpwc_pkg::MUL_A_W-1:0];
            mul_b    = {1'b0, gain_d_ff};
            state_in = bpwc_pkg::ST_ACC;
         end
         bpwc_pkg::ST_ACC: begin
            acc_in   = acc_ff + prod_ff;
            state_in = bpwc_pkg::ST_FB;
         end
         bpwc_pkg::ST_FB: begin
            // round half up and drop to Q16.16
            fb_in    = acc_round[bpwc_pkg::ACC_W-1:bpwc_pkg::FRAC_DROP];
            state_in = bpwc_pkg::ST_CMD;
         end
         bpwc_pkg::ST_CMD: begin
            // hold here while the previous response still waits
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               rsp_in.left_wheel_cmd = sat_cmd(
                  bpwc_pkg::CMD_SUM_W'(req_ff.left_wheel_pos) +
                  bpwc_pkg::CMD_SUM_W'(fb_ff));
               rsp_in.right_wheel_cmd = sat_cmd(
                  bpwc_pkg::CMD_SUM_W'(req_ff.right_wheel_pos) +
                  bpwc_pkg::CMD_SUM_W'(fb_ff));
               state_in = bpwc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bpwc_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   // shared multiplier, registered
   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpwc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      err_ff  <= err_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      fb_ff   <= fb_in;
      rsp_ff  <= rsp_in;
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == bpwc_pkg::ST_ERR))
      else $error("accepted request did not start the error step");

   a_integral_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpwc_pkg::ST_ERR && err_sat >= level_ff) |=> (sum_ff == '0))
      else $error("integral not cleared at or above reset level");

   a_prev_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpwc_pkg::ST_ERR) |=> (prev_ff == $past(err_sat)))
      else $error("previous error not updated from this tick");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == bpwc_pkg::ST_CMD))
      else $error("response raised outside the command step");
`endif

endmodule

/* tb/tb_balance_pid_wheel_command.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the balance PID wheel command block.
module tb_balance_pid_wheel_command;

   // Setup the block comes out of reset with (gains in Q8.8, angles in Q4.12)
   localparam logic [15:0]        KP_DEFAULT     = 16'd19200;
   localparam logic [15:0]        KI_DEFAULT     = 16'd2560;
   localparam logic [15:0]        KD_DEFAULT     = 16'd25600;
   localparam logic signed [15:0] SETPOINT_DEFAULT = 16'sd0;
   localparam logic signed [15:0] LEVEL_DEFAULT  = 16'sd205;
   localparam longint             RATE_FACTOR    = 200;   // derivative rate scaling
   localparam longint             Q16_MAX        = 64'sd2147483647;
   localparam longint             Q16_MIN        = -64'sd2147483648;
   localparam int                 RESET_CYCLES   = 12;
   localparam int                 DRAIN_CYCLES   = 12;    // quiet time after the last response
   localparam int                 WATCHDOG_LIMIT = 2000;
   localparam int                 PRINT_CAP      = 200;
   localparam int                 RANDOM_PHASES  = 6;
   localparam int                 TICKS_PER_PHASE = 320;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   bpwc_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   bpwc_pkg::rsp_payload_type rsp_payload;
   logic                                csr_wr_en = 1'b0;
   logic [bpwc_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [bpwc_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   // Mirror of the block's setup and control state
   logic [15:0]        kp_q8, ki_q8, kd_q8;
   logic signed [15:0] pitch_setpoint, clear_level;
   longint             integ_sum, last_err;

   bpwc_pkg::req_payload_type tick_queue[$];      // requests not yet presented
   bpwc_pkg::rsp_payload_type expected_cmds[$];   // wheel commands owed by the block
   bpwc_pkg::rsp_payload_type next_cmd;
   int in_flight = 0;                   // queued requests still owed a response
   int mismatches = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   int quiet_cycles = 0;

   balance_pid_wheel_command dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic longint clamp_q16(input longint v);
      if (v > Q16_MAX)
         return Q16_MAX;
      if (v < Q16_MIN)
         return Q16_MIN;
      return v;
   endfunction

   // One control tick: update the integral and last error, return both commands.
   function automatic bpwc_pkg::rsp_payload_type predict_wheel_cmds(
      input bpwc_pkg::req_payload_type tick
   );
      longint                    err;
      longint                    drive;
      longint                    feedback;
      bpwc_pkg::rsp_payload_type cmd;
      err = longint'($signed(tick.pitch_angle)) - longint'(pitch_setpoint);
      // saturate the error to 16 bits before it is used or stored
      if (err > 32767)
         err = 32767;
      if (err < -32768)
         err = -32768;
      // clear the integral once the error reaches the reset level
      if (err < longint'(clear_level))
         integ_sum = clamp_q16(integ_sum + err);
      else
         integ_sum = 0;
      drive = longint'(kp_q8) * err + longint'(ki_q8) * integ_sum
            + longint'(kd_q8) * RATE_FACTOR * (err - last_err);
      // Q12.20 to Q16.16, round half up
      feedback = (drive + 8) >>> 4;
      cmd.left_wheel_cmd  = 32'(clamp_q16(longint'($signed(tick.left_wheel_pos)) + feedback));
      cmd.right_wheel_cmd = 32'(clamp_q16(longint'($signed(tick.right_wheel_pos)) + feedback));
      last_err = err;
      return cmd;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t ns: %s got %h want %h", $time, what, got, want);
   endtask

   // Write one register; the mirror follows at once since no request is in flight.
   task automatic csr_write(input logic [bpwc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         bpwc_pkg::REG_GAIN_P: kp_q8 = value;
         bpwc_pkg::REG_GAIN_I: ki_q8 = value;
         bpwc_pkg::REG_GAIN_D: kd_q8 = value;
         bpwc_pkg::REG_TARGET: pitch_setpoint = value;
         bpwc_pkg::REG_LEVEL:  clear_level = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic csr_setup(input logic [15:0] kp, input logic [15:0] ki,
                            input logic [15:0] kd, input logic [15:0] target,
                            input logic [15:0] level);
      csr_write(bpwc_pkg::REG_GAIN_P, kp);
      csr_write(bpwc_pkg::REG_GAIN_I, ki);
      csr_write(bpwc_pkg::REG_GAIN_D, kd);
      csr_write(bpwc_pkg::REG_TARGET, target);
      csr_write(bpwc_pkg::REG_LEVEL, level);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_tick(input logic [15:0] pitch, input logic [31:0] left,
                             input logic [31:0] right);
      bpwc_pkg::req_payload_type tick;
      tick.pitch_angle     = pitch;
      tick.left_wheel_pos  = left;
      tick.right_wheel_pos = right;
      tick_queue.push_back(tick);
      in_flight++;
   endtask

   // Wait for every owed response, then let the pipeline go quiet before a setup change.
   task automatic settle();
      while (in_flight != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_position();
      case ($urandom_range(0, 4))
         0: return {16'h7FFF, 16'($urandom)};
         1: return {16'h8000, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 1023));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 2000) - 1000);
         default: return 16'($urandom);
      endcase
   endfunction

   // Request driver: present queued ticks, idle in short random bursts,
   // and predict each tick's commands at the edge it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready)
            expected_cmds.push_back(predict_wheel_cmds(req_payload));
         // hold a request the block has not taken yet
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (tick_queue.size() == 0) begin
               req_valid <= 1'b0;
            end else if ($urandom_range(0, 99) < req_idle_pct) begin
               req_gap = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else begin
               req_valid   <= 1'b1;
               req_payload <= tick_queue.pop_front();
            end
         end
      end
   end

   // Response monitor: check each command pair against the oldest prediction,
   // and stall the result channel in short random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cmds.size() == 0) begin
               report_mismatch("response with no request pending",
                               rsp_payload.left_wheel_cmd, '0);
            end else begin
               next_cmd = expected_cmds.pop_front();
               if (rsp_payload.left_wheel_cmd !== next_cmd.left_wheel_cmd)
                  report_mismatch("left_wheel_cmd", rsp_payload.left_wheel_cmd,
                                  next_cmd.left_wheel_cmd);
               if (rsp_payload.right_wheel_cmd !== next_cmd.right_wheel_cmd)
                  report_mismatch("right_wheel_cmd", rsp_payload.right_wheel_cmd,
                                  next_cmd.right_wheel_cmd);
               in_flight--;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_gap = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      int phase;
      int n;
      logic [15:0] pitch;

      kp_q8          = KP_DEFAULT;
      ki_q8          = KI_DEFAULT;
      kd_q8          = KD_DEFAULT;
      pitch_setpoint = SETPOINT_DEFAULT;
      clear_level    = LEVEL_DEFAULT;
      integ_sum      = 0;
      last_err       = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset setup, errors around the reset level, wheel extremes
      req_idle_pct  = 25;
      rsp_stall_pct = 25;
      queue_tick(16'sd0, 32'd0, 32'd0);
      queue_tick(16'sd204, 32'd1, 32'hFFFF_FFFF);          // just below the level
      queue_tick(16'sd204, 32'd1, 32'hFFFF_FFFF);          // integral grows
      queue_tick(16'sd205, 32'd0, 32'd0);                  // level reached: clear
      queue_tick(16'sd206, 32'd0, 32'd0);
      queue_tick(16'h8000, 32'h7FFF_FFFF, 32'h8000_0000);  // drive low: right clamps
      queue_tick(16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000);  // drive high: left clamps
      queue_tick(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      settle();

      // Directed: unknown indexes dropped, then gains at full scale, lowest target and level
      for (n = int'(bpwc_pkg::REG_LEVEL) + 1; n < (1 << bpwc_pkg::CSR_INDEX_W); n++)
         csr_write(bpwc_pkg::CSR_INDEX_W'(n), 16'($urandom));
      csr_setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000);
      queue_tick(16'h7FFF, 32'h0000_0000, 32'hFFFF_FFFF);  // error clamps high
      queue_tick(16'h8000, 32'h7FFF_FFFF, 32'h8000_0000);  // zero error, above the level
      queue_tick(16'h0000, 32'h8000_0000, 32'h0000_0001);
      queue_tick(16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      settle();

      // Directed: gains zero, highest target and level; commands follow positions
      csr_setup(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF);
      queue_tick(16'h8000, 32'h8000_0000, 32'h7FFF_FFFF);  // error clamps low
      queue_tick(16'h7FFF, 32'h1234_5678, 32'hEDCB_A988);  // zero error
      queue_tick(16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
      settle();

      // Random phases: fresh setup each time, pitch mostly near the target so the
      // integral builds, now and then anywhere; the last phase runs without idling.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end else begin
            req_idle_pct  = 20 * $urandom_range(0, 3);
            rsp_stall_pct = 20 * $urandom_range(0, 3);
         end
         if ($urandom_range(0, 1))
            csr_write(bpwc_pkg::CSR_INDEX_W'($urandom_range(
                         int'(bpwc_pkg::REG_LEVEL) + 1,
                         (1 << bpwc_pkg::CSR_INDEX_W) - 1)), 16'($urandom));
         csr_setup(pick_gain(), pick_gain(), pick_gain(), pick_angle(), pick_angle());
         for (n = 0; n < TICKS_PER_PHASE; n++) begin
            if ($urandom_range(0, 3) == 0)
               pitch = 16'($urandom);
            else
               pitch = pitch_setpoint + 16'($urandom_range(0, 600) - 300);
            queue_tick(pitch, pick_position(), pick_position());
         end
         settle();
      end

      if (mismatches == 0 && in_flight == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
